// ===== hdl/sled_pkg.sv =====
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and codes for the status LED pattern driver.
// ----------------------------------------------------------------------------
package sled_pkg;

    // Colour codes
    localparam logic [1:0] COL_OFF   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_RED   = 2'd2;
    localparam logic [1:0] COL_AMBER = 2'd3;

    // Pattern codes
    localparam logic [2:0] PAT_SOLID  = 3'd0;
    localparam logic [2:0] PAT_SLOW   = 3'd1;
    localparam logic [2:0] PAT_FAST   = 3'd2;
    localparam logic [2:0] PAT_DOUBLE = 3'd3;
    localparam logic [2:0] PAT_ALT    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_FATAL     = 3'd0;
    localparam logic [2:0] ST_FAULT     = 3'd1;
    localparam logic [2:0] ST_NO_FRAMES = 3'd2;
    localparam logic [2:0] ST_STREAMING = 3'd3;
    localparam logic [2:0] ST_READY     = 3'd4;
    localparam logic [2:0] ST_NO_HOST   = 3'd5;
    localparam logic [2:0] ST_BOOT      = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_ACTIVE_HIGH = 3'd0;
    localparam logic [2:0] REG_BLINK_SLOW  = 3'd1;
    localparam logic [2:0] REG_BLINK_FAST  = 3'd2;
    localparam logic [2:0] REG_DBL_PERIOD  = 3'd3;
    localparam logic [2:0] REG_DBL_PULSE   = 3'd4;
    localparam logic [2:0] REG_DBL_GAP     = 3'd5;
    localparam logic [2:0] REG_ALT_SLOT    = 3'd6;
    localparam logic [2:0] REG_BOOT_COLOR  = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SLOT_W     = 14;

    typedef struct packed {
        logic [2:0] status_code;
        logic       degraded;
    } in_t;

    typedef struct packed {
        logic       green_pin;
        logic       red_pin;
        logic [1:0] shown_color;
        logic [2:0] shown_pattern;
    } out_t;

    // Divider status towards the top level
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [1:0]        quot_lo;
        logic [SLOT_W-1:0] rem;
    } div_res_t;

endpackage

// ===== hdl/sled_div.sv =====
// ----------------------------------------------------------------------------
// sled_div
// Bit-serial restoring divider: phase / slot, keeps the remainder and the
// two low quotient bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module sled_div #(
    parameter int PHASE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [PHASE_BITS-1:0]         dividend,
    input  logic [sled_pkg::SLOT_W-1:0]   divisor,
    output sled_pkg::div_res_t            res
);

    localparam int CNT_W = $clog2(PHASE_BITS + 1);
    localparam int SW    = sled_pkg::SLOT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0] dvd_reg, dvd_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [1:0]        quot_reg, quot_next;

    logic [SW:0]       trial;
    logic              ge;
    logic [SW-1:0]     diff;

    assign trial = {rem_reg, dvd_reg[PHASE_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial[SW-1:0] - divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(PHASE_BITS);
            dvd_next  = dividend;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract where it fits
            rem_next  = ge ? diff : trial[SW-1:0];
            quot_next = {quot_reg[0], ge};
            dvd_next  = {dvd_reg[PHASE_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign res.busy    = busy_reg;
    assign res.done    = done_reg;
    assign res.quot_lo = quot_reg;
    assign res.rem     = rem_reg;

endmodule

// ===== hdl/status_led_pattern_driver.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_driver
// Maps device status to an LED colour and pattern and drives the pin levels.
// ----------------------------------------------------------------------------
// A tick transfer shows in the output register in the following cycle.
// One tick per cycle when not stalled, set by the single output register.
// After a write to the alternating slot length the input stalls
// while the serial divider rebuilds the slot position.
// Reset: registers take their defaults, all phases clear, output empties.
// ----------------------------------------------------------------------------
module status_led_pattern_driver #(
    parameter int PHASE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // tick channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sled_pkg::in_t                      in_data,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output sled_pkg::out_t                     out_data,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [sled_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sled_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW = sled_pkg::SLOT_W;
    // compare width: wide enough for phases and for every derived bound
    localparam int CW = (PHASE_BITS > 16) ? PHASE_BITS : 16;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          active_high_reg;
    logic [SW-1:0] blink_slow_reg;
    logic [SW-1:0] blink_fast_reg;
    logic [15:0]   dbl_period_reg;
    logic [SW-1:0] dbl_pulse_reg;
    logic [SW-1:0] dbl_gap_reg;
    logic [SW-1:0] alt_slot_reg;
    logic [1:0]    boot_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg <= 1'b1;
            blink_slow_reg  <= SW'(500);
            blink_fast_reg  <= SW'(100);
            dbl_period_reg  <= 16'd1000;
            dbl_pulse_reg   <= SW'(100);
            dbl_gap_reg     <= SW'(100);
            alt_slot_reg    <= SW'(250);
            boot_color_reg  <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sled_pkg::REG_ACTIVE_HIGH: active_high_reg <= cfg_data[0];
                sled_pkg::REG_BLINK_SLOW:  blink_slow_reg  <= cfg_data[SW-1:0];
                sled_pkg::REG_BLINK_FAST:  blink_fast_reg  <= cfg_data[SW-1:0];
                sled_pkg::REG_DBL_PERIOD:  dbl_period_reg  <= cfg_data[15:0];
                sled_pkg::REG_DBL_PULSE:   dbl_pulse_reg   <= cfg_data[SW-1:0];
                sled_pkg::REG_DBL_GAP:     dbl_gap_reg     <= cfg_data[SW-1:0];
                sled_pkg::REG_ALT_SLOT:    alt_slot_reg    <= cfg_data[SW-1:0];
                sled_pkg::REG_BOOT_COLOR:  boot_color_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Zero blink, period and slot lengths behave as one millisecond
    logic [SW-1:0] slow_eff, fast_eff, slot_eff;
    logic [15:0]   period_eff;

    assign slow_eff   = (blink_slow_reg == '0) ? SW'(1) : blink_slow_reg;
    assign fast_eff   = (blink_fast_reg == '0) ? SW'(1) : blink_fast_reg;
    assign slot_eff   = (alt_slot_reg == '0)   ? SW'(1) : alt_slot_reg;
    assign period_eff = (dbl_period_reg == '0) ? 16'd1 : dbl_period_reg;

    // ------------------------------------------------------------------
    // Phase counters and the alternating slot position
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] slow_ph_reg, fast_ph_reg, dbl_ph_reg, alt_ph_reg;
    logic [PHASE_BITS-1:0] slow_ph_next, fast_ph_next, dbl_ph_next, alt_ph_next;
    // alt phase split as quotient (low two bits) and remainder by the slot
    logic [SW-1:0]         alt_rem_reg, alt_rem_next;
    logic [1:0]            alt_q_reg, alt_q_next;

    logic [PHASE_BITS-1:0] slow_inc, fast_inc, dbl_inc, alt_inc;
    logic [CW-1:0]         slow_mod, fast_mod, dbl_mod, alt_mod;
    logic                  alt_zero;

    // ------------------------------------------------------------------
    // Slot position rebuild after a slot length write
    // ------------------------------------------------------------------
    logic               div_start_reg;
    sled_pkg::div_res_t div_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_start_reg <= 1'b0;
        else
            div_start_reg <= cfg_we && (cfg_index == sled_pkg::REG_ALT_SLOT);
    end

    sled_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (alt_ph_reg),
        .divisor  (slot_eff),
        .res      (div_res)
    );

    // ------------------------------------------------------------------
    // Handshake: hold ticks while the output is full and stalled, or while
    // the slot position is being rebuilt
    // ------------------------------------------------------------------
    logic   out_valid_reg;
    logic   in_xfer;
    logic   out_xfer;

    assign in_stall = (out_valid_reg && out_stall) || div_start_reg
                      || div_res.busy || div_res.done;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // Colour and pattern selection
    // ------------------------------------------------------------------
    logic [1:0] col;
    logic [2:0] pat;

    always_comb
    begin
        case (in_data.status_code)
            sled_pkg::ST_FATAL:
            begin
                col = sled_pkg::COL_RED;
                pat = sled_pkg::PAT_FAST;
            end
            sled_pkg::ST_FAULT:
            begin
                col = sled_pkg::COL_RED;
                pat = sled_pkg::PAT_DOUBLE;
            end
            sled_pkg::ST_NO_FRAMES:
            begin
                col = sled_pkg::COL_RED;
                pat = sled_pkg::PAT_SLOW;
            end
            sled_pkg::ST_STREAMING, sled_pkg::ST_READY:
            begin
                col = sled_pkg::COL_GREEN;
                pat = sled_pkg::PAT_SOLID;
            end
            sled_pkg::ST_NO_HOST:
            begin
                col = sled_pkg::COL_AMBER;
                pat = sled_pkg::PAT_ALT;
            end
            sled_pkg::ST_BOOT:
            begin
                col = boot_color_reg;
                pat = sled_pkg::PAT_FAST;
            end
            default:
            begin
                col = sled_pkg::COL_OFF;
                pat = sled_pkg::PAT_SOLID;
            end
        endcase
        // degraded turns green into amber
        if (in_data.degraded && col == sled_pkg::COL_GREEN)
            col = sled_pkg::COL_AMBER;
    end

    // ------------------------------------------------------------------
    // Lit decisions from the phases as they stand at the tick
    // ------------------------------------------------------------------
    logic [15:0] dbl_second, dbl_end;
    logic        slow_lit, fast_lit, dbl_lit, pat_lit;
    logic        g_lit, r_lit;

    assign dbl_second = 16'(dbl_pulse_reg) + 16'(dbl_gap_reg);
    assign dbl_end    = dbl_second + 16'(dbl_pulse_reg);

    assign slow_lit = CW'(slow_ph_reg) < CW'(slow_eff);
    assign fast_lit = CW'(fast_ph_reg) < CW'(fast_eff);
    assign dbl_lit  = (CW'(dbl_ph_reg) < CW'(dbl_pulse_reg))
                      || ((CW'(dbl_ph_reg) >= CW'(dbl_second))
                          && (CW'(dbl_ph_reg) < CW'(dbl_end)));

    always_comb
    begin
        case (pat)
            sled_pkg::PAT_SLOW:   pat_lit = slow_lit;
            sled_pkg::PAT_FAST:   pat_lit = fast_lit;
            sled_pkg::PAT_DOUBLE: pat_lit = dbl_lit;
            default:              pat_lit = 1'b1;
        endcase

        g_lit = 1'b0;
        r_lit = 1'b0;
        case (col)
            sled_pkg::COL_GREEN:
            begin
                // a green double blink or solid shows as steady on
                g_lit = (pat == sled_pkg::PAT_SLOW || pat == sled_pkg::PAT_FAST)
                        ? pat_lit : 1'b1;
            end
            sled_pkg::COL_RED:
            begin
                r_lit = pat_lit;
            end
            sled_pkg::COL_AMBER:
            begin
                if (pat == sled_pkg::PAT_ALT)
                begin
                    // slot one lights both, slot three green only
                    g_lit = alt_q_reg[0];
                    r_lit = (alt_q_reg == 2'd1);
                end
                else
                begin
                    g_lit = pat_lit;
                    r_lit = pat_lit;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Phase advance: step by one, wrap at the modulus or the phase width
    // ------------------------------------------------------------------
    assign slow_mod = CW'({slow_eff, 1'b0});
    assign fast_mod = CW'({fast_eff, 1'b0});
    assign dbl_mod  = CW'(period_eff);
    assign alt_mod  = CW'({slot_eff, 2'b00});

    assign slow_inc = slow_ph_reg + 1'b1;
    assign fast_inc = fast_ph_reg + 1'b1;
    assign dbl_inc  = dbl_ph_reg + 1'b1;
    assign alt_inc  = alt_ph_reg + 1'b1;

    assign alt_zero = (CW'(alt_inc) >= alt_mod) || (alt_inc == '0);

    always_comb
    begin
        slow_ph_next = slow_ph_reg;
        fast_ph_next = fast_ph_reg;
        dbl_ph_next  = dbl_ph_reg;
        alt_ph_next  = alt_ph_reg;
        alt_rem_next = alt_rem_reg;
        alt_q_next   = alt_q_reg;
        if (div_res.done)
        begin
            // take the rebuilt slot position
            alt_rem_next = div_res.rem;
            alt_q_next   = div_res.quot_lo;
        end
        else if (in_xfer)
        begin
            slow_ph_next = (CW'(slow_inc) >= slow_mod) ? '0 : slow_inc;
            fast_ph_next = (CW'(fast_inc) >= fast_mod) ? '0 : fast_inc;
            dbl_ph_next  = (CW'(dbl_inc) >= dbl_mod)   ? '0 : dbl_inc;
            if (alt_zero)
            begin
                alt_ph_next  = '0;
                alt_rem_next = '0;
                alt_q_next   = '0;
            end
            else
            begin
                alt_ph_next = alt_inc;
                if (alt_rem_reg + 1'b1 == slot_eff)
                begin
                    alt_rem_next = '0;
                    alt_q_next   = alt_q_reg + 1'b1;
                end
                else
                begin
                    alt_rem_next = alt_rem_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_ph_reg <= '0;
            fast_ph_reg <= '0;
            dbl_ph_reg  <= '0;
            alt_ph_reg  <= '0;
            alt_rem_reg <= '0;
            alt_q_reg   <= '0;
        end
        else
        begin
            slow_ph_reg <= slow_ph_next;
            fast_ph_reg <= fast_ph_next;
            dbl_ph_reg  <= dbl_ph_next;
            alt_ph_reg  <= alt_ph_next;
            alt_rem_reg <= alt_rem_next;
            alt_q_reg   <= alt_q_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on each tick transfer, drop once taken
    // ------------------------------------------------------------------
    logic           out_valid_next;
    sled_pkg::out_t out_data_reg, out_data_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_xfer)
        begin
            out_valid_next               = 1'b1;
            // apply polarity: active low inverts both pins
            out_data_next.green_pin      = g_lit ^ !active_high_reg;
            out_data_next.red_pin        = r_lit ^ !active_high_reg;
            out_data_next.shown_color    = col;
            out_data_next.shown_pattern  = pat;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/sled_checker.sv =====
// ----------------------------------------------------------------------------
// sled_checker
// Port-level checks for the status LED pattern driver, bound to the top.
// ----------------------------------------------------------------------------
module sled_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  sled_pkg::out_t                     out_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    // every tick transfer yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("tick transfer gave no result");

    // off colour leaves both pins at the same (dark) level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.shown_color == sled_pkg::COL_OFF
        |-> out_data.green_pin == out_data.red_pin)
        else $error("off colour with mismatched pins");

    // alternating pattern only comes in amber
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.shown_pattern == sled_pkg::PAT_ALT
        |-> out_data.shown_color == sled_pkg::COL_AMBER)
        else $error("alternating pattern in a colour other than amber");

endmodule

bind status_led_pattern_driver sled_checker u_sled_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the status LED pattern driver. Tick transfers are
// offered with random gaps and the result channel is stalled at random. A
// behavioural copy of the colour, pattern and phase logic predicts every
// result, and each result is compared field by field. Register settings
// change between rounds: defaults, zero lengths, extremes and short periods.
// ----------------------------------------------------------------------------
module tb;

    localparam int          PHASE_BITS    = 16;
    localparam logic [31:0] PHASE_MASK    = 32'((64'd1 << PHASE_BITS) - 64'd1);
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          FREEZE_CYCLES = 80;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          ROUNDS        = 22;
    localparam int          TICKS_PER_RND = 55;

    // Ways of choosing the lengths for one round of random ticks
    typedef enum int {
        STYLE_TINY,
        STYLE_SHORT,
        STYLE_MAX,
        STYLE_MIN,
        STYLE_MIXED
    } setting_style_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    sled_pkg::in_t                   in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    sled_pkg::out_t                  out_data;
    logic                            cfg_we    = 1'b0;
    logic [sled_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sled_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the registers, starting from their reset values
    logic        cfg_active_high = 1'b1;
    logic [13:0] cfg_slow_half   = 14'd500;
    logic [13:0] cfg_fast_half   = 14'd100;
    logic [15:0] cfg_dbl_period  = 16'd1000;
    logic [13:0] cfg_dbl_pulse   = 14'd100;
    logic [13:0] cfg_dbl_gap     = 14'd100;
    logic [13:0] cfg_alt_slot    = 14'd250;
    logic [1:0]  cfg_boot_color  = sled_pkg::COL_AMBER;

    // Shadow millisecond phases, all clear after reset
    logic [31:0] slow_ph = '0;
    logic [31:0] fast_ph = '0;
    logic [31:0] dbl_ph  = '0;
    logic [31:0] alt_ph  = '0;

    // LED results still owed by the block, oldest first
    sled_pkg::out_t pending_leds[$];

    bit send_gaps_on  = 1'b1;
    bit stall_gaps_on = 1'b1;
    bit freeze_req    = 1'b0;

    int fail_count    = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int freezes_done  = 0;
    int cycles        = 0;

    status_led_pattern_driver #(
        .PHASE_BITS (PHASE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: a hung handshake or a lost result ends here
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A zero length behaves as one millisecond
    function automatic logic [31:0] floor_one(logic [31:0] v);
        return (v == 32'd0) ? 32'd1 : v;
    endfunction

    // Advance one millisecond; a stale phase at or past the modulus wraps here
    function automatic logic [31:0] phase_after(logic [31:0] ph, logic [31:0] modulus);
        logic [31:0] nxt;
        nxt = (ph + 32'd1) & PHASE_MASK;
        return (nxt >= modulus) ? 32'd0 : nxt;
    endfunction

    function automatic logic pattern_on(logic [2:0] pat);
        logic [31:0] second;
        second = 32'(cfg_dbl_pulse) + 32'(cfg_dbl_gap);
        case (pat)
            sled_pkg::PAT_SLOW:   return slow_ph < floor_one(32'(cfg_slow_half));
            sled_pkg::PAT_FAST:   return fast_ph < floor_one(32'(cfg_fast_half));
            sled_pkg::PAT_DOUBLE: return (dbl_ph < 32'(cfg_dbl_pulse)) ||
                                         (dbl_ph >= second &&
                                          dbl_ph < second + 32'(cfg_dbl_pulse));
            default:              return 1'b1;
        endcase
    endfunction

    // Work out the LED result for one tick, then move every phase on by one
    function automatic sled_pkg::out_t light_for_tick(sled_pkg::in_t tick);
        logic [1:0]     colour;
        logic [2:0]     pat;
        logic           g;
        logic           r;
        logic [31:0]    slot;
        sled_pkg::out_t res;
        g = 1'b0;
        r = 1'b0;
        case (tick.status_code)
            sled_pkg::ST_FATAL:
                {colour, pat} = {sled_pkg::COL_RED, sled_pkg::PAT_FAST};
            sled_pkg::ST_FAULT:
                {colour, pat} = {sled_pkg::COL_RED, sled_pkg::PAT_DOUBLE};
            sled_pkg::ST_NO_FRAMES:
                {colour, pat} = {sled_pkg::COL_RED, sled_pkg::PAT_SLOW};
            sled_pkg::ST_STREAMING:
                {colour, pat} = {sled_pkg::COL_GREEN, sled_pkg::PAT_SOLID};
            sled_pkg::ST_READY:
                {colour, pat} = {sled_pkg::COL_GREEN, sled_pkg::PAT_SOLID};
            sled_pkg::ST_NO_HOST:
                {colour, pat} = {sled_pkg::COL_AMBER, sled_pkg::PAT_ALT};
            sled_pkg::ST_BOOT:
                {colour, pat} = {cfg_boot_color, sled_pkg::PAT_FAST};
            default:
                {colour, pat} = {sled_pkg::COL_OFF, sled_pkg::PAT_SOLID};
        endcase
        if (tick.degraded && colour == sled_pkg::COL_GREEN)
            colour = sled_pkg::COL_AMBER;

        // Green only blinks slow or fast; anything else is steady on
        if (colour == sled_pkg::COL_GREEN)
            g = (pat == sled_pkg::PAT_SLOW || pat == sled_pkg::PAT_FAST)
                ? pattern_on(pat) : 1'b1;
        else if (colour == sled_pkg::COL_RED)
            r = pattern_on(pat);
        else if (colour == sled_pkg::COL_AMBER)
        begin
            if (pat == sled_pkg::PAT_ALT)
            begin
                slot = (alt_ph / floor_one(32'(cfg_alt_slot))) & 32'd3;
                g    = (slot == 32'd1 || slot == 32'd3);
                r    = (slot == 32'd1);
            end
            else
            begin
                g = pattern_on(pat);
                r = g;
            end
        end

        if (!cfg_active_high)
        begin
            g = ~g;
            r = ~r;
        end
        res.green_pin     = g;
        res.red_pin       = r;
        res.shown_color   = colour;
        res.shown_pattern = pat;

        slow_ph = phase_after(slow_ph, 32'd2 * floor_one(32'(cfg_slow_half)));
        fast_ph = phase_after(fast_ph, 32'd2 * floor_one(32'(cfg_fast_half)));
        dbl_ph  = phase_after(dbl_ph, floor_one(32'(cfg_dbl_period)));
        alt_ph  = phase_after(alt_ph, 32'd4 * floor_one(32'(cfg_alt_slot)));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall per result, long hold-off on request, checks
    // ------------------------------------------------------------------------
    task automatic check_leds(sled_pkg::out_t got);
        sled_pkg::out_t want;
        results_seen++;
        if (pending_leds.size() == 0)
        begin
            $error("LED result with no tick outstanding: %b", got);
            fail_count++;
            return;
        end
        want = pending_leds.pop_front();
        if (got.green_pin !== want.green_pin)
        begin
            $error("green_pin: expected %0d, got %0d", want.green_pin, got.green_pin);
            fail_count++;
        end
        if (got.red_pin !== want.red_pin)
        begin
            $error("red_pin: expected %0d, got %0d", want.red_pin, got.red_pin);
            fail_count++;
        end
        if (got.shown_color !== want.shown_color)
        begin
            $error("shown_color: expected %0d, got %0d", want.shown_color, got.shown_color);
            fail_count++;
        end
        if (got.shown_pattern !== want.shown_pattern)
        begin
            $error("shown_pattern: expected %0d, got %0d",
                   want.shown_pattern, got.shown_pattern);
            fail_count++;
        end
    endtask

    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            // Sample the pre-edge values: a transfer happened at this edge
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                check_leds(out_data);
                hold_left = stall_gaps_on ? $urandom_range(0, 4) : 0;
            end
            // Long hold-off, counted here, so the block fills and stalls its input
            if (freeze_req)
            begin
                hold_left  = FREEZE_CYCLES;
                freeze_req = 1'b0;
                freezes_done++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Tick side
    // ------------------------------------------------------------------------

    // Offer one tick; returns at the edge of its transfer with valid still high
    task automatic send_tick(logic [2:0] status, logic degraded);
        int            gap;
        sled_pkg::in_t tick;
        gap              = send_gaps_on ? $urandom_range(0, 4) : 0;
        tick.status_code = status;
        tick.degraded    = degraded;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_leds.push_back(light_for_tick(tick));
        ticks_sent++;
    endtask

    task automatic send_random_ticks(int count);
        repeat (count)
            send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_leds.size() != 0)
            @(posedge clk);
    endtask

    // One register write; only called with the block idle
    task automatic write_reg(logic [sled_pkg::CFG_IDX_W-1:0] idx,
                             logic [sled_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            sled_pkg::REG_ACTIVE_HIGH: cfg_active_high = value[0];
            sled_pkg::REG_BLINK_SLOW:  cfg_slow_half   = value[13:0];
            sled_pkg::REG_BLINK_FAST:  cfg_fast_half   = value[13:0];
            sled_pkg::REG_DBL_PERIOD:  cfg_dbl_period  = value;
            sled_pkg::REG_DBL_PULSE:   cfg_dbl_pulse   = value[13:0];
            sled_pkg::REG_DBL_GAP:     cfg_dbl_gap     = value[13:0];
            sled_pkg::REG_ALT_SLOT:    cfg_alt_slot    = value[13:0];
            sled_pkg::REG_BOOT_COLOR:  cfg_boot_color  = value[1:0];
            default:                   cfg_boot_color  = cfg_boot_color;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_len(setting_style_t style, logic [15:0] top);
        case (style)
            STYLE_TINY:  return 16'($urandom_range(0, 6));
            STYLE_SHORT: return 16'($urandom_range(1, 40));
            STYLE_MAX:   return top;
            STYLE_MIN:   return 16'($urandom_range(0, 1));
            default:     return $urandom_range(0, 1) ? top - 16'($urandom_range(0, 3))
                                                     : 16'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic program_settings(setting_style_t style);
        write_reg(sled_pkg::REG_ACTIVE_HIGH, 16'($urandom_range(0, 1)));
        write_reg(sled_pkg::REG_BLINK_SLOW, pick_len(style, 16'd16383));
        write_reg(sled_pkg::REG_BLINK_FAST, pick_len(style, 16'd16383));
        write_reg(sled_pkg::REG_DBL_PERIOD, pick_len(style, 16'd65535));
        write_reg(sled_pkg::REG_DBL_PULSE, pick_len(style, 16'd16383));
        write_reg(sled_pkg::REG_DBL_GAP, pick_len(style, 16'd16383));
        write_reg(sled_pkg::REG_ALT_SLOT, pick_len(style, 16'd16383));
        write_reg(sled_pkg::REG_BOOT_COLOR, 16'($urandom_range(0, 3)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every status with and without degraded, at the reset settings
    task automatic test_status_map();
        for (int s = 0; s < 8; s++)
        begin
            send_tick(s[2:0], 1'b0);
            send_tick(s[2:0], 1'b1);
        end
    endtask

    // Shrink the periods below the running phases: judge stale, then wrap
    task automatic test_stale_phase();
        wait_idle();
        write_reg(sled_pkg::REG_BLINK_SLOW, 16'd3);
        write_reg(sled_pkg::REG_BLINK_FAST, 16'd2);
        write_reg(sled_pkg::REG_DBL_PERIOD, 16'd5);
        write_reg(sled_pkg::REG_ALT_SLOT, 16'd2);
        send_tick(sled_pkg::ST_NO_FRAMES, 1'b0);
        send_tick(sled_pkg::ST_FATAL, 1'b0);
        send_tick(sled_pkg::ST_FAULT, 1'b0);
        send_tick(sled_pkg::ST_NO_HOST, 1'b0);
    endtask

    // Zero lengths act as one millisecond; also low-active pins, green boot
    task automatic test_zero_durations();
        wait_idle();
        write_reg(sled_pkg::REG_BLINK_SLOW, 16'd0);
        write_reg(sled_pkg::REG_BLINK_FAST, 16'd0);
        write_reg(sled_pkg::REG_DBL_PERIOD, 16'd0);
        write_reg(sled_pkg::REG_DBL_PULSE, 16'd0);
        write_reg(sled_pkg::REG_DBL_GAP, 16'd0);
        write_reg(sled_pkg::REG_ALT_SLOT, 16'd0);
        write_reg(sled_pkg::REG_BOOT_COLOR, 16'(sled_pkg::COL_GREEN));
        write_reg(sled_pkg::REG_ACTIVE_HIGH, 16'd0);
        send_tick(sled_pkg::ST_NO_FRAMES, 1'b0);
        send_tick(sled_pkg::ST_FATAL, 1'b0);
        send_tick(sled_pkg::ST_FAULT, 1'b0);
        send_tick(sled_pkg::ST_NO_HOST, 1'b0);
        send_tick(sled_pkg::ST_BOOT, 1'b0);
        send_tick(sled_pkg::ST_BOOT, 1'b1);
    endtask

    // Rounds of random ticks, each under fresh settings; some rounds run flat out
    task automatic test_random_settings();
        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            wait_idle();
            program_settings(setting_style_t'(rnd % 5));
            send_gaps_on  = (rnd % 4 != 3);
            stall_gaps_on = (rnd % 3 != 2);
            send_random_ticks(TICKS_PER_RND);
        end
        send_gaps_on  = 1'b1;
        stall_gaps_on = 1'b1;
    endtask

    // Receiver holds off while ticks keep coming back to back
    task automatic test_backpressure();
        wait_idle();
        program_settings(STYLE_SHORT);
        send_gaps_on = 1'b0;
        freeze_req   = 1'b1;
        send_random_ticks(40);
        send_gaps_on = 1'b1;
    endtask

    initial
    begin : run
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_status_map();
        test_stale_phase();
        test_zero_durations();
        test_random_settings();
        test_backpressure();

        // Let any stray result show up before the verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ticks across all status codes and %0d register writes,",
                 ticks_sent, reg_writes);
        $display("checked %0d results with %0d long receiver hold-off(s), %0d mismatch(es).",
                 results_seen, freezes_done, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
